@@ hdl/ubd_pkg.sv @@
// Shared types, constants and helper functions for the UART baud divisor calculator.
// Has no dependencies. Used by ubd_div_stage and uart_baud_divisor_calc.
package ubd_pkg;

  // Field widths
  localparam int unsigned BaudW = 24;
  localparam int unsigned WordW = 16;
  localparam int unsigned IntW  = 14;

  // Dividend is base clock times eight: 96e6 fits in 27 bits
  localparam int unsigned DvdW = 27;
  localparam logic [DvdW-1:0] DvdHigh = 27'd96000000;
  localparam logic [DvdW-1:0] DvdLow  = 27'd24000000;

  // Integer divisor limits
  localparam logic [IntW-1:0] IntMax = 14'h3FFF;
  localparam logic [IntW-1:0] IntMin = 14'd1;

  // Divider pipeline shape: quotient bits resolved per stage, stage count
  localparam int unsigned StepsPerStage = 3;
  localparam int unsigned NumStages     = DvdW / StepsPerStage;

  // Divider work item: partial remainder, dividend/quotient shift word
  typedef struct packed {
    logic [BaudW-1:0] rem;
    logic [DvdW-1:0]  dq;
    logic [BaudW-1:0] dvs;
    logic             err;
  } div_t;

  // Restoring division, StepsPerStage quotient bits
  function automatic div_t div_steps(div_t s);
    div_t           r;
    logic [BaudW:0] t;
    r = s;
    for (int i = 0; i < StepsPerStage; i++) begin
      t    = {r.rem, r.dq[DvdW-1]};
      r.dq = {r.dq[DvdW-2:0], 1'b0};
      if (t >= {1'b0, r.dvs}) begin
        t       = t - {1'b0, r.dvs};
        r.dq[0] = 1'b1;
      end
      r.rem = t[BaudW-1:0];
    end
    return r;
  endfunction

  // Fraction remap, eighths to encoded code
  function automatic logic [2:0] frac_code(logic [2:0] f);
    logic [2:0] c;
    case (f)
      3'd0:    c = 3'd0;
      3'd1:    c = 3'd3;
      3'd2:    c = 3'd2;
      3'd3:    c = 3'd4;
      3'd4:    c = 3'd1;
      3'd5:    c = 3'd5;
      3'd6:    c = 3'd6;
      3'd7:    c = 3'd7;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

@@ hdl/ubd_div_stage.sv @@
// One registered stage of the pipelined restoring divider.
// Depends on ubd_pkg (div_t, div_steps).
module ubd_div_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  ubd_pkg::div_t data_i,
  output logic          rdy_o,
  output logic          valid_o,
  output ubd_pkg::div_t data_o,
  input  logic          rdy_i
);

  logic          valid_q;
  ubd_pkg::div_t data_q;
  ubd_pkg::div_t data_d;

  // Stage can load when empty or when its content moves on
  assign rdy_o  = !valid_q || rdy_i;
  assign data_d = ubd_pkg::div_steps(data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rdy_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (valid_i && rdy_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ hdl/uart_baud_divisor_calc.sv @@
// Top level of the UART baud divisor calculator: divider pipeline plus output stage.
// Depends on ubd_pkg and ubd_div_stage.
//
// Takes one baud rate word per cycle while in_stall_o is low and returns one
// 16-bit divisor word per input, in order: nine divider stages resolve three
// quotient bits each of base*8/baud_rate, and
// a final register applies the 1..16383 clamp and the fraction remap. Bits 13:0
// hold the integer divisor, bits 15:14 the low two bits of the remapped
// fraction. A zero rate gives word 0 with divide_error set. high_clock selects
// a 12 MHz (1) or 3 MHz (0) base; change it only while the pipeline is empty.
// A stall on the output backs up through the stages; in_stall_o rises only once
// every stage holds a word.
module uart_baud_divisor_calc (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic                     cfg_high_clock_i,
  // request
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ubd_pkg::BaudW-1:0] baud_rate_i,
  // result
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [ubd_pkg::WordW-1:0] divisor_word_o,
  output logic                     divide_error_o
);

  localparam int unsigned NS = ubd_pkg::NumStages;

  // Configuration register
  logic high_clock_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_clock_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      high_clock_q <= cfg_high_clock_i;
    end
  end

  // Stage chain: index 0 is the input, index NS the last divider stage
  logic          st_valid [NS+1];
  logic          st_rdy   [NS+1];
  ubd_pkg::div_t st_data  [NS+1];

  // Load the dividend for the selected base clock, the divisor and the zero-rate error flag
  assign st_valid[0]    = in_valid_i;
  assign st_data[0].rem = '0;
  assign st_data[0].dq  = high_clock_q ? ubd_pkg::DvdHigh : ubd_pkg::DvdLow;
  assign st_data[0].dvs = baud_rate_i;
  assign st_data[0].err = (baud_rate_i == '0);
  assign in_stall_o     = !st_rdy[0];

  for (genvar g = 0; g < NS; g++) begin : g_div
    ubd_div_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(st_valid[g]),
      .data_i (st_data[g]),
      .rdy_o  (st_rdy[g]),
      .valid_o(st_valid[g+1]),
      .data_o (st_data[g+1]),
      .rdy_i  (st_rdy[g+1])
    );
  end

  // Output stage: clamp, fraction remap, word assembly
  logic                      out_valid_q;
  logic [ubd_pkg::WordW-1:0] word_q, word_d;
  logic                      err_q;
  logic [ubd_pkg::DvdW-4:0]  int_part;
  logic [ubd_pkg::IntW-1:0]  int_clamp;
  logic [2:0]                code;

  assign st_rdy[NS] = !out_valid_q || !out_stall_i;

  always_comb begin
    int_part = st_data[NS].dq[ubd_pkg::DvdW-1:3];
    code     = ubd_pkg::frac_code(st_data[NS].dq[2:0]);
    if (int_part == '0) begin
      int_clamp = ubd_pkg::IntMin;
    end else if (int_part > {{(ubd_pkg::DvdW-3-ubd_pkg::IntW){1'b0}}, ubd_pkg::IntMax}) begin
      int_clamp = ubd_pkg::IntMax;
    end else begin
      int_clamp = int_part[ubd_pkg::IntW-1:0];
    end
    if (st_data[NS].err) begin
      word_d = '0;
    end else begin
      word_d = {code[1:0], int_clamp};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (st_rdy[NS]) begin
      out_valid_q <= st_valid[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_valid[NS] && st_rdy[NS]) begin
      word_q <= word_d;
      err_q  <= st_data[NS].err;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign divisor_word_o = word_q;
  assign divide_error_o = err_q;

  // An error word carries no divisor bits
  a_err_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_error_o |-> divisor_word_o == '0)
    else $error("error word has nonzero divisor");

  // A good word never has a zero integer divisor
  a_int_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !divide_error_o |-> divisor_word_o[ubd_pkg::IntW-1:0] != '0)
    else $error("integer divisor is zero");

  // Input stalls only when the first stage holds a word that cannot move
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> st_valid[1] && out_valid_q && out_stall_i)
    else $error("input stalled with room in pipeline");

  // A word held at the output under stall keeps the last divider stage's word in place
  a_last_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i && st_valid[NS] |=> st_valid[NS])
    else $error("last divider stage lost its word under stall");

endmodule
